// File: design/ncc_pkg.sv
// shared types and constants for the nearest centroid classifier
// used by ncc_ctrl, ncc_datapath and nearest_centroid_classifier; no dependencies
package ncc_pkg;

	localparam int NUM_CL     = 8;
	localparam int CL_BITS    = 3;
	localparam int NUM_DIMS   = 16;
	localparam int DIM_BITS   = 4;
	localparam int CNT_BITS   = 5;
	localparam int FEAT_BITS  = 16;
	localparam int DIFF_BITS  = FEAT_BITS + 1;
	localparam int SQ_BITS    = 2 * FEAT_BITS;
	localparam int DIST_BITS  = 36;
	localparam int ADDR_BITS  = CL_BITS + DIM_BITS;
	localparam int NCL_BITS   = 4;
	localparam int CFG_BITS   = 5;
	localparam int IN_BYTES   = 3;
	localparam int OUT_BYTES  = 5;

	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_POINT = 1'b1;

	localparam logic REG_NUM_CLUSTERS = 1'b0;
	localparam logic REG_NUM_DIMS     = 1'b1;

	localparam logic [NCL_BITS-1:0] NUM_CL_RESET   = NCL_BITS'(NUM_CL);
	localparam logic [CFG_BITS-1:0] NUM_DIMS_RESET = CFG_BITS'(NUM_DIMS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_DRAIN,
		ST_SEARCH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic               wr;
		logic               load;
		logic               issue;
		logic               cnt_inc;
		logic               search;
		logic               first;
		logic               emit;
		logic [CL_BITS-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic use_feat;
		logic out_full;
	} sts_t;

endpackage

// File: design/ncc_ctrl.sv
// controller state machine for the nearest centroid classifier
// depends on ncc_pkg; drives ncc_datapath through cmd_t, reads sts_t
module ncc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            in_opcode,
	input  logic            in_last,
	input  ncc_pkg::sts_t   sts,
	output ncc_pkg::cmd_t   cmd
);

	ncc_pkg::state_t                  state_q, state_d;
	logic [ncc_pkg::CL_BITS-1:0]      idx_q, idx_d;
	logic                             last_q, last_d;
	logic                             accept;

	localparam logic [ncc_pkg::CL_BITS-1:0] IDX_LAST = ncc_pkg::CL_BITS'(ncc_pkg::NUM_CL - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ncc_pkg::ST_IDLE;
			idx_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			last_q  <= last_d;
		end
	end

	assign accept = in_valid && (state_q == ncc_pkg::ST_IDLE);

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		last_d   = last_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.idx  = idx_q;
		case (state_q)
			ncc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				idx_d    = '0;
				if (accept) begin
					if (in_opcode == ncc_pkg::OP_WRITE) begin
						cmd.wr = 1'b1;
					end else begin
						cmd.load = 1'b1;
						last_d   = in_last;
						if (sts.use_feat) begin
							state_d = ncc_pkg::ST_ACC;
						end else if (in_last) begin
							state_d = ncc_pkg::ST_SEARCH;
						end
					end
				end
			end
			ncc_pkg::ST_ACC: begin
				cmd.issue = 1'b1;
				idx_d     = idx_q + 1'b1;
				if (idx_q == IDX_LAST) begin
					cmd.cnt_inc = 1'b1;
					idx_d       = '0;
					state_d     = ncc_pkg::ST_DRAIN;
				end
			end
			ncc_pkg::ST_DRAIN: begin
				if (!sts.busy) begin
					state_d = last_q ? ncc_pkg::ST_SEARCH : ncc_pkg::ST_IDLE;
				end
			end
			ncc_pkg::ST_SEARCH: begin
				cmd.search = 1'b1;
				cmd.first  = (idx_q == '0);
				idx_d      = idx_q + 1'b1;
				if (idx_q == IDX_LAST) begin
					idx_d   = '0;
					state_d = ncc_pkg::ST_EMIT;
				end
			end
			ncc_pkg::ST_EMIT: begin
				if (!sts.out_full) begin
					cmd.emit = 1'b1;
					state_d  = ncc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ncc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: design/ncc_datapath.sv
// datapath: centroid memory, squared difference pipeline, accumulator ring,
// minimum search, configuration registers and output register; depends on ncc_pkg
module ncc_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ncc_pkg::cmd_t                       cmd,
	output ncc_pkg::sts_t                       sts,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [ncc_pkg::CFG_BITS-1:0]        cfg_data,
	input  logic [ncc_pkg::CL_BITS-1:0]         in_centroid,
	input  logic [ncc_pkg::DIM_BITS-1:0]        in_feature,
	input  logic signed [ncc_pkg::FEAT_BITS-1:0] in_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ncc_pkg::CL_BITS-1:0]         out_label,
	output logic [ncc_pkg::DIST_BITS-1:0]       out_dist
);

	logic signed [ncc_pkg::FEAT_BITS-1:0] mem [ncc_pkg::NUM_CL * ncc_pkg::NUM_DIMS];

	logic [ncc_pkg::NCL_BITS-1:0]  num_clusters_q;
	logic [ncc_pkg::CFG_BITS-1:0]  num_dims_q;
	logic [ncc_pkg::NCL_BITS-1:0]  clusters;
	logic [ncc_pkg::CFG_BITS-1:0]  dims;

	logic [ncc_pkg::CNT_BITS-1:0]  cnt_q;
	logic signed [ncc_pkg::FEAT_BITS-1:0] value_q;

	logic                                  v_s1, v_s2, v_s3;
	logic signed [ncc_pkg::FEAT_BITS-1:0]  rdata_s1;
	logic signed [ncc_pkg::DIFF_BITS-1:0]  diff_s2;
	logic [ncc_pkg::SQ_BITS-1:0]           sq_s3;
	logic signed [2*ncc_pkg::DIFF_BITS-1:0] prod;

	logic [ncc_pkg::DIST_BITS-1:0] acc_q [ncc_pkg::NUM_CL];
	logic [ncc_pkg::DIST_BITS:0]   sum;
	logic [ncc_pkg::DIST_BITS-1:0] sat;
	logic [ncc_pkg::DIST_BITS-1:0] shift_in;

	logic [ncc_pkg::DIST_BITS-1:0] best_q;
	logic [ncc_pkg::CL_BITS-1:0]   best_idx_q;
	logic                          cand_ok;

	logic                          out_valid_q;
	logic [ncc_pkg::CL_BITS-1:0]   out_label_q;
	logic [ncc_pkg::DIST_BITS-1:0] out_dist_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clusters_q <= ncc_pkg::NUM_CL_RESET;
			num_dims_q     <= ncc_pkg::NUM_DIMS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == ncc_pkg::REG_NUM_CLUSTERS) begin
				num_clusters_q <= cfg_data[ncc_pkg::NCL_BITS-1:0];
			end else begin
				num_dims_q <= cfg_data;
			end
		end
	end

	always_comb begin
		clusters = num_clusters_q;
		if (num_clusters_q == '0) begin
			clusters = ncc_pkg::NCL_BITS'(1);
		end else if (num_clusters_q > ncc_pkg::NUM_CL_RESET) begin
			clusters = ncc_pkg::NUM_CL_RESET;
		end
		dims = num_dims_q;
		if (num_dims_q == '0) begin
			dims = ncc_pkg::CFG_BITS'(1);
		end else if (num_dims_q > ncc_pkg::NUM_DIMS_RESET) begin
			dims = ncc_pkg::NUM_DIMS_RESET;
		end
	end

	// centroid memory and point value
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[{in_centroid, in_feature}] <= in_value;
		end
		if (cmd.issue) begin
			rdata_s1 <= mem[{cmd.idx, cnt_q[ncc_pkg::DIM_BITS-1:0]}];
		end
		if (cmd.load) begin
			value_q <= in_value;
		end
		diff_s2 <= ncc_pkg::DIFF_BITS'(value_q) - ncc_pkg::DIFF_BITS'(rdata_s1);
		sq_s3   <= prod[ncc_pkg::SQ_BITS-1:0];
	end

	assign prod = diff_s2 * diff_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			cnt_q <= '0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.search && cmd.first) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// accumulator ring, head is always the centroid being processed
	assign sum      = {1'b0, acc_q[0]} + (ncc_pkg::DIST_BITS+1)'(sq_s3);
	assign sat      = sum[ncc_pkg::DIST_BITS] ? ncc_pkg::DIST_MAX : sum[ncc_pkg::DIST_BITS-1:0];
	assign shift_in = v_s3 ? sat : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ncc_pkg::NUM_CL; i++) begin
				acc_q[i] <= '0;
			end
		end else if (v_s3 || cmd.search) begin
			for (int i = 0; i < ncc_pkg::NUM_CL - 1; i++) begin
				acc_q[i] <= acc_q[i+1];
			end
			acc_q[ncc_pkg::NUM_CL-1] <= shift_in;
		end
	end

	// minimum search, lowest index wins ties
	assign cand_ok = (ncc_pkg::NCL_BITS'(cmd.idx) < clusters) && (acc_q[0] < best_q);

	always_ff @(posedge clk) begin
		if (cmd.search) begin
			if (cmd.first) begin
				best_q     <= acc_q[0];
				best_idx_q <= '0;
			end else if (cand_ok) begin
				best_q     <= acc_q[0];
				best_idx_q <= cmd.idx;
			end
		end
		if (cmd.emit) begin
			out_label_q <= best_idx_q;
			out_dist_q  <= best_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_label = out_label_q;
	assign out_dist  = out_dist_q;

	assign sts.busy     = v_s1 || v_s2 || v_s3;
	assign sts.use_feat = (cnt_q < dims);
	assign sts.out_full = out_valid_q && !out_ready;

endmodule

// File: design/nearest_centroid_classifier.sv
// top level of the nearest centroid classifier
// depends on ncc_pkg, ncc_ctrl and ncc_datapath
//
// usage:
//  - cfg_we/cfg_index/cfg_data write num_clusters (index 0) or num_dims (index 1)
//    while the block is idle; reset values are 8 and 16
//  - s_axis items: tuser is the opcode (0 centroid write, 1 point feature),
//    tlast marks the last feature of a point
//  - a centroid write is stored in centroid memory while the block stays idle
//  - a point feature that counts makes 8 memory reads, one per centroid,
//    through a read / subtract / square / accumulate pipeline sharing one multiplier,
//    then drains that pipeline; a feature past num_dims skips the reads
//  - the last feature then runs an 8 step minimum search over the
//    accumulator ring, then loads the output register
//  - m_axis carries label and distance_squared from a result register; a new item
//    is accepted while a result waits, and the block only stalls before loading
//    its next result when the receiver holds tready low
//  - reset clears accumulators, feature count and handshake state and sets the config
//    to its reset values; centroid memory holds garbage until written
module nearest_centroid_classifier (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [ncc_pkg::CFG_BITS-1:0]      cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// centroid_index[2:0], feature_index[6:3], feature_value[22:7], zero pad[23]
	input  logic [8*ncc_pkg::IN_BYTES-1:0]    s_axis_tdata,
	// opcode
	input  logic                              s_axis_tuser,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// label[2:0], distance_squared[38:3], zero pad[39]
	output logic [8*ncc_pkg::OUT_BYTES-1:0]   m_axis_tdata
);

	localparam int FI_LO = ncc_pkg::CL_BITS;
	localparam int FV_LO = ncc_pkg::CL_BITS + ncc_pkg::DIM_BITS;
	localparam int IN_USED  = FV_LO + ncc_pkg::FEAT_BITS;
	localparam int OUT_USED = ncc_pkg::CL_BITS + ncc_pkg::DIST_BITS;

	ncc_pkg::cmd_t                  cmd;
	ncc_pkg::sts_t                  sts;
	logic [ncc_pkg::CL_BITS-1:0]    label;
	logic [ncc_pkg::DIST_BITS-1:0]  distance_squared;

	ncc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_opcode (s_axis_tuser),
		.in_last   (s_axis_tlast),
		.sts       (sts),
		.cmd       (cmd)
	);

	ncc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_centroid (s_axis_tdata[FI_LO-1:0]),
		.in_feature  (s_axis_tdata[FV_LO-1:FI_LO]),
		.in_value    (s_axis_tdata[IN_USED-1:FV_LO]),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_label   (label),
		.out_dist    (distance_squared)
	);

	assign m_axis_tdata = {(8*ncc_pkg::OUT_BYTES - OUT_USED)'(0), distance_squared, label};

endmodule
